// ===== rtl/svg_pkg.sv =====
`timescale 1ns / 1ps

package svg_pkg;

	// Grid geometry.
	localparam int OUTER_BITS  = 4;
	localparam int MIDDLE_BITS = 3;
	localparam int LEAF_BITS   = 3;
	localparam int TOTAL_BITS  = OUTER_BITS + MIDDLE_BITS + LEAF_BITS;

	localparam int MIDDLE_POOL_BLOCKS = 64;
	localparam int LEAF_POOL_BLOCKS   = 1024;
	localparam int VALUE_WIDTH        = 32;

	// Port widths fixed by the interface.
	localparam int CELL_W = 10;
	localparam int DATA_W = 32;

	// Sign-extended axis width, wide enough for the offset sum and a range test.
	localparam int EXT_W = ((TOTAL_BITS > CELL_W) ? TOTAL_BITS : CELL_W) + 2;

	// Flattened index widths of each level.
	localparam int OUTER_IDX_W = 3 * OUTER_BITS;
	localparam int MID_IDX_W   = 3 * MIDDLE_BITS;
	localparam int LEAF_IDX_W  = 3 * LEAF_BITS;

	// Block pointer and pool counter widths.
	localparam int MID_PTR_W  = (MIDDLE_POOL_BLOCKS > 1) ? $clog2(MIDDLE_POOL_BLOCKS) : 1;
	localparam int LEAF_PTR_W = (LEAF_POOL_BLOCKS > 1) ? $clog2(LEAF_POOL_BLOCKS) : 1;
	localparam int MID_CNT_W  = $clog2(MIDDLE_POOL_BLOCKS + 1);
	localparam int LEAF_CNT_W = $clog2(LEAF_POOL_BLOCKS + 1);

	// Memory address widths.
	localparam int OUTER_ADDR_W = OUTER_IDX_W;
	localparam int MID_ADDR_W   = MID_PTR_W + MID_IDX_W;
	localparam int LEAF_ADDR_W  = LEAF_PTR_W + LEAF_IDX_W;

	localparam int MAX_AB_W = (OUTER_ADDR_W > MID_ADDR_W) ? OUTER_ADDR_W : MID_ADDR_W;
	localparam int CLR_W    = (MAX_AB_W > LEAF_ADDR_W) ? MAX_AB_W : LEAF_ADDR_W;

	typedef logic signed [EXT_W-1:0] ext_t;
	typedef logic [VALUE_WIDTH-1:0]  value_t;
	typedef logic [DATA_W-1:0]       data_t;
	typedef logic [MID_CNT_W-1:0]    mid_cnt_t;
	typedef logic [LEAF_CNT_W-1:0]   leaf_cnt_t;
	typedef logic [OUTER_ADDR_W-1:0] outer_addr_t;
	typedef logic [MID_ADDR_W-1:0]   mid_addr_t;
	typedef logic [LEAF_ADDR_W-1:0]  leaf_addr_t;
	typedef logic [CLR_W-1:0]        clr_cnt_t;

	localparam ext_t AXIS_OFFSET = ext_t'(1) <<< (TOTAL_BITS - 1);

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_POOL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RANGE,
		S_OUTER,
		S_MIDDLE,
		S_LEAF
	} state_t;

	// Decoded cell index handed from the index unit to the controller.
	typedef struct packed {
		logic                   in_range;
		logic [OUTER_IDX_W-1:0] oi;
		logic [MID_IDX_W-1:0]   mi;
		logic [LEAF_IDX_W-1:0]  li;
	} idx_t;

	typedef struct packed {
		logic                 valid;
		logic [MID_PTR_W-1:0] ptr;
	} outer_entry_t;

	typedef struct packed {
		logic                  valid;
		logic [LEAF_PTR_W-1:0] ptr;
	} mid_entry_t;

endpackage

// ===== rtl/svg_ram.sv =====
`timescale 1ns / 1ps

// Single-port synchronous RAM; read data is registered and holds between reads.
module svg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/svg_index.sv =====
`timescale 1ns / 1ps

// Offsets each signed axis to unsigned, checks range and splits it into the
// three level parts, each flattened z-major.
module svg_index (
	input  logic signed [svg_pkg::CELL_W-1:0] cell_x,
	input  logic signed [svg_pkg::CELL_W-1:0] cell_y,
	input  logic signed [svg_pkg::CELL_W-1:0] cell_z,
	output svg_pkg::idx_t                     idx
);

	localparam int T = svg_pkg::TOTAL_BITS;
	localparam int M = svg_pkg::MIDDLE_BITS;
	localparam int L = svg_pkg::LEAF_BITS;

	svg_pkg::ext_t vx, vy, vz;

	assign vx = svg_pkg::ext_t'(cell_x) + svg_pkg::AXIS_OFFSET;
	assign vy = svg_pkg::ext_t'(cell_y) + svg_pkg::AXIS_OFFSET;
	assign vz = svg_pkg::ext_t'(cell_z) + svg_pkg::AXIS_OFFSET;

	// A shifted axis is in range when nothing is set at or above the grid edge,
	// which also rules out a negative sum.
	assign idx.in_range = (vx[svg_pkg::EXT_W-1:T] == '0) &&
		(vy[svg_pkg::EXT_W-1:T] == '0) && (vz[svg_pkg::EXT_W-1:T] == '0);

	assign idx.oi = {vz[T-1:M+L], vy[T-1:M+L], vx[T-1:M+L]};
	assign idx.mi = {vz[M+L-1:L], vy[M+L-1:L], vx[M+L-1:L]};
	assign idx.li = {vz[L-1:0], vy[L-1:0], vx[L-1:0]};

endmodule

// ===== rtl/sparse_voxel_grid_store_core.sv =====
`timescale 1ns / 1ps

// Sparse three-level voxel store. A request on the req channel (req_valid,
// req_stall) reads or writes one cell at a signed (x,y,z) index; each request
// gives exactly one response on the rsp channel (rsp_valid, rsp_stall) with
// read_data, status and allocated. A request is taken when valid is high and
// stall is low.
// Requests are served one at a time: the outer directory, the middle
// directory and the leaf store are read one after another, each read
// registered in its RAM, and a write that needs a new middle block
// finishes straight after the outer read. The response is written to the
// output register when the request finishes.
// After reset the three memories are cleared in parallel, one entry a cycle,
// over all 2^19 leaf addresses; req_stall stays high until the pass is done.
// The output register lets the next request be taken while a response waits.
// If a response finds the register still held by a stalled receiver, the
// request finishing holds its state, and its memory writes, until it frees.
module sparse_voxel_grid_store_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              kind,
	input  logic signed [svg_pkg::CELL_W-1:0] cell_x,
	input  logic signed [svg_pkg::CELL_W-1:0] cell_y,
	input  logic signed [svg_pkg::CELL_W-1:0] cell_z,
	input  logic [svg_pkg::DATA_W-1:0]        write_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [svg_pkg::DATA_W-1:0]        read_data,
	output logic [1:0]                        status,
	output logic                              allocated
);

	svg_pkg::state_t state_q, state_d;
	svg_pkg::idx_t   idx;

	// Held request.
	svg_pkg::kind_t                        kind_q;
	logic [svg_pkg::OUTER_IDX_W-1:0]       oi_q;
	logic [svg_pkg::MID_IDX_W-1:0]         mi_q;
	logic [svg_pkg::LEAF_IDX_W-1:0]        li_q;
	svg_pkg::value_t                       wdata_q;
	svg_pkg::mid_addr_t                    ma_q, ma_d;
	logic                                  cap, ma_load;

	// Pool counters and clearing pass.
	svg_pkg::mid_cnt_t  mbu_q;
	svg_pkg::leaf_cnt_t lbu_q;
	logic               mbu_inc, lbu_inc;
	svg_pkg::clr_cnt_t  clr_q;

	// Memory ports.
	logic                  o_en, o_we, m_en, m_we, l_en, l_we;
	svg_pkg::outer_addr_t  o_addr;
	svg_pkg::mid_addr_t    m_addr;
	svg_pkg::leaf_addr_t   l_addr;
	svg_pkg::outer_entry_t o_wdata, o_rdata;
	svg_pkg::mid_entry_t   m_wdata, m_rdata;
	svg_pkg::value_t       l_wdata, l_rdata;

	// Response register.
	logic              rsp_valid_q;
	svg_pkg::data_t    read_data_q, fin_data;
	svg_pkg::status_t  status_q, fin_status;
	logic              allocated_q, fin_alloc;
	logic              fin, out_free;

	logic mid_full, leaf_full;

	svg_index u_index (
		.cell_x (cell_x),
		.cell_y (cell_y),
		.cell_z (cell_z),
		.idx    (idx)
	);

	svg_ram #(
		.WIDTH ($bits(svg_pkg::outer_entry_t)),
		.DEPTH (1 << svg_pkg::OUTER_ADDR_W)
	) u_outer_ram (
		.clk   (clk),
		.en    (o_en),
		.we    (o_we),
		.addr  (o_addr),
		.wdata (o_wdata),
		.rdata (o_rdata)
	);

	svg_ram #(
		.WIDTH ($bits(svg_pkg::mid_entry_t)),
		.DEPTH (1 << svg_pkg::MID_ADDR_W)
	) u_middle_ram (
		.clk   (clk),
		.en    (m_en),
		.we    (m_we),
		.addr  (m_addr),
		.wdata (m_wdata),
		.rdata (m_rdata)
	);

	svg_ram #(
		.WIDTH (svg_pkg::VALUE_WIDTH),
		.DEPTH (1 << svg_pkg::LEAF_ADDR_W)
	) u_leaf_ram (
		.clk   (clk),
		.en    (l_en),
		.we    (l_we),
		.addr  (l_addr),
		.wdata (l_wdata),
		.rdata (l_rdata)
	);

	assign mid_full  = (mbu_q >= svg_pkg::mid_cnt_t'(svg_pkg::MIDDLE_POOL_BLOCKS));
	assign leaf_full = (lbu_q >= svg_pkg::leaf_cnt_t'(svg_pkg::LEAF_POOL_BLOCKS));
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d    = state_q;
		cap        = 1'b0;
		ma_load    = 1'b0;
		ma_d       = {o_rdata.ptr, mi_q};
		mbu_inc    = 1'b0;
		lbu_inc    = 1'b0;
		o_en       = 1'b0;
		o_we       = 1'b0;
		o_addr     = idx.oi;
		o_wdata    = '0;
		m_en       = 1'b0;
		m_we       = 1'b0;
		m_addr     = ma_d;
		m_wdata    = '0;
		l_en       = 1'b0;
		l_we       = 1'b0;
		l_addr     = {m_rdata.ptr, li_q};
		l_wdata    = wdata_q;
		fin        = 1'b0;
		fin_status = svg_pkg::STATUS_OK;
		fin_data   = '0;
		fin_alloc  = 1'b0;

		case (state_q)
			svg_pkg::S_CLEAR: begin
				// Every memory is swept together; the smaller ones simply wrap.
				o_en    = 1'b1;
				o_we    = 1'b1;
				o_addr  = clr_q[svg_pkg::OUTER_ADDR_W-1:0];
				m_en    = 1'b1;
				m_we    = 1'b1;
				m_addr  = clr_q[svg_pkg::MID_ADDR_W-1:0];
				l_en    = 1'b1;
				l_we    = 1'b1;
				l_addr  = clr_q[svg_pkg::LEAF_ADDR_W-1:0];
				l_wdata = '0;
				if (clr_q == '1) begin
					state_d = svg_pkg::S_IDLE;
				end
			end
			svg_pkg::S_IDLE: begin
				if (req_valid) begin
					cap = 1'b1;
					if (idx.in_range) begin
						o_en    = 1'b1;
						o_addr  = idx.oi;
						state_d = svg_pkg::S_OUTER;
					end else begin
						state_d = svg_pkg::S_RANGE;
					end
				end
			end
			svg_pkg::S_RANGE: begin
				fin = 1'b1;
				if (kind_q == svg_pkg::KIND_WRITE) begin
					fin_status = svg_pkg::STATUS_RANGE;
				end
			end
			svg_pkg::S_OUTER: begin
				if (o_rdata.valid) begin
					// Middle block exists: look up the leaf pointer.
					m_en    = 1'b1;
					m_addr  = ma_d;
					ma_load = 1'b1;
					state_d = svg_pkg::S_MIDDLE;
				end else if (kind_q == svg_pkg::KIND_READ) begin
					fin = 1'b1;
				end else if (mid_full || leaf_full) begin
					fin        = 1'b1;
					fin_status = svg_pkg::STATUS_POOL;
				end else begin
					// Fresh middle and leaf blocks come out of the clearing pass
					// empty, so all three writes go out together.
					fin         = 1'b1;
					fin_alloc   = 1'b1;
					mbu_inc     = 1'b1;
					lbu_inc     = 1'b1;
					o_en        = 1'b1;
					o_we        = 1'b1;
					o_addr      = oi_q;
					o_wdata.valid = 1'b1;
					o_wdata.ptr   = mbu_q[svg_pkg::MID_PTR_W-1:0];
					m_en        = 1'b1;
					m_we        = 1'b1;
					m_addr      = {mbu_q[svg_pkg::MID_PTR_W-1:0], mi_q};
					m_wdata.valid = 1'b1;
					m_wdata.ptr   = lbu_q[svg_pkg::LEAF_PTR_W-1:0];
					l_en        = 1'b1;
					l_we        = 1'b1;
					l_addr      = {lbu_q[svg_pkg::LEAF_PTR_W-1:0], li_q};
				end
			end
			svg_pkg::S_MIDDLE: begin
				if (kind_q == svg_pkg::KIND_READ) begin
					if (m_rdata.valid) begin
						l_en    = 1'b1;
						l_addr  = {m_rdata.ptr, li_q};
						state_d = svg_pkg::S_LEAF;
					end else begin
						fin = 1'b1;
					end
				end else if (m_rdata.valid) begin
					fin    = 1'b1;
					l_en   = 1'b1;
					l_we   = 1'b1;
					l_addr = {m_rdata.ptr, li_q};
				end else if (leaf_full) begin
					fin        = 1'b1;
					fin_status = svg_pkg::STATUS_POOL;
				end else begin
					fin           = 1'b1;
					fin_alloc     = 1'b1;
					lbu_inc       = 1'b1;
					m_en          = 1'b1;
					m_we          = 1'b1;
					m_addr        = ma_q;
					m_wdata.valid = 1'b1;
					m_wdata.ptr   = lbu_q[svg_pkg::LEAF_PTR_W-1:0];
					l_en          = 1'b1;
					l_we          = 1'b1;
					l_addr        = {lbu_q[svg_pkg::LEAF_PTR_W-1:0], li_q};
				end
			end
			svg_pkg::S_LEAF: begin
				fin      = 1'b1;
				fin_data = svg_pkg::data_t'(l_rdata);
			end
			default: begin
				state_d = svg_pkg::S_IDLE;
			end
		endcase

		// A finishing request waits, writes and all, until the response
		// register can take its result.
		if (fin) begin
			if (out_free) begin
				state_d = svg_pkg::S_IDLE;
			end else begin
				state_d = state_q;
				mbu_inc = 1'b0;
				lbu_inc = 1'b0;
				o_en    = 1'b0;
				m_en    = 1'b0;
				l_en    = 1'b0;
				o_we    = 1'b0;
				m_we    = 1'b0;
				l_we    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svg_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			mbu_q       <= '0;
			lbu_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == svg_pkg::S_CLEAR) begin
				clr_q <= clr_q + svg_pkg::clr_cnt_t'(1);
			end
			if (mbu_inc) begin
				mbu_q <= mbu_q + svg_pkg::mid_cnt_t'(1);
			end
			if (lbu_inc) begin
				lbu_q <= lbu_q + svg_pkg::leaf_cnt_t'(1);
			end
			if (fin && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			kind_q  <= svg_pkg::kind_t'(kind);
			oi_q    <= idx.oi;
			mi_q    <= idx.mi;
			li_q    <= idx.li;
			wdata_q <= svg_pkg::value_t'(write_data);
		end
		if (ma_load) begin
			ma_q <= ma_d;
		end
		if (fin && out_free) begin
			read_data_q <= fin_data;
			status_q    <= fin_status;
			allocated_q <= fin_alloc;
		end
	end

	assign req_stall = (state_q != svg_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign allocated = allocated_q;

endmodule
